// ===== rtl/srd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the sprite run-length span decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = 13;   // holds 0..MAX_DIMENSION
	localparam int POS_W         = 12;   // row / column of a span
	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 7;    // palette bytes still due
	localparam int CFG_IDX_W     = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] encoded_byte;
		logic              sprite_start;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  span_row;
		logic [POS_W-1:0]  span_column;
		logic [DIM_W-1:0]  span_length;
		logic [BYTE_W-1:0] palette_index;
		logic              opaque;
		logic              row_complete;
		logic              sprite_complete;
	} span_t;

	// zero maps to 1, anything above MAX_DIMENSION maps to MAX_DIMENSION
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIMENSION))
			r = DIM_W'(MAX_DIMENSION);
		else
			r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/srd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_core
// Decode state (row, column, mode, byte count) and the one-byte step logic.
// ----------------------------------------------------------------------------
module srd_core import srd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire item_t            item,
	input  wire logic [DIM_W-1:0] sprite_width,
	input  wire logic [DIM_W-1:0] sprite_height,
	output      span_t            span,
	output      logic             span_emit
);

	localparam logic [2:0] MODE_CMD      = 3'd0;
	localparam logic [2:0] MODE_OPAQUE   = 3'd1;
	localparam logic [2:0] MODE_SKIPDATA = 3'd2;
	localparam logic [2:0] MODE_SEEK     = 3'd3;
	localparam logic [2:0] MODE_DONE     = 3'd4;

	logic [POS_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [2:0]       mode_q;
	logic [CNT_W-1:0] cnt_q;

	logic [POS_W-1:0] row_d;
	logic [DIM_W-1:0] col_d;
	logic [2:0]       mode_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [BYTE_W-1:0] b;
		logic              row_last;
		logic [DIM_W-1:0]  left;
		logic [DIM_W-1:0]  n;
		logic [DIM_W-1:0]  len;
		logic              full;
		logic [2:0]        nm;

		w = clamp_dim(sprite_width);
		h = clamp_dim(sprite_height);
		b = item.encoded_byte;

		row_d  = row_q;
		col_d  = col_q;
		mode_d = mode_q;
		cnt_d  = cnt_q;

		span      = '0;
		span_emit = 1'b0;
		left = '0;
		n    = '0;
		len  = '0;
		full = 1'b0;
		nm   = MODE_SEEK;

		if (item.sprite_start) begin
			row_d  = '0;
			col_d  = '0;
			mode_d = MODE_CMD;
			cnt_d  = '0;
		end
		if (mode_d > MODE_DONE)
			mode_d = MODE_DONE;
		if (mode_d == MODE_OPAQUE && cnt_d == '0)
			mode_d = MODE_CMD;

		row_last = (({1'b0, row_d} + DIM_W'(1)) >= h);

		// width or height shrank under a sprite in flight
		if (mode_d == MODE_CMD || mode_d == MODE_OPAQUE) begin
			if ({1'b0, row_d} >= h) begin
				mode_d = MODE_DONE;
			end else if (col_d >= w) begin
				nm    = (mode_d == MODE_OPAQUE) ? MODE_SKIPDATA : MODE_SEEK;
				col_d = '0;
				if (row_last) begin
					mode_d = MODE_DONE;
				end else begin
					row_d  = row_d + POS_W'(1);
					mode_d = nm;
				end
			end
		end

		span.span_row    = row_d;
		span.span_column = col_d[POS_W-1:0];

		unique case (mode_d)
			MODE_CMD: begin
				left = w - col_d;
				if (b == '0) begin
					span_emit                = 1'b1;
					span.span_length         = left;
					span.row_complete        = 1'b1;
					span.sprite_complete     = row_last;
					col_d = '0;
					if (row_last) begin
						mode_d = MODE_DONE;
					end else begin
						row_d  = row_d + POS_W'(1);
						mode_d = MODE_CMD;
					end
				end else if (b[BYTE_W-1]) begin
					n    = DIM_W'(9'd256 - {1'b0, b});
					full = (n >= left);
					len  = full ? left : n;
					span_emit            = 1'b1;
					span.span_length     = len;
					span.row_complete    = full;
					span.sprite_complete = full && row_last;
					if (full) begin
						col_d = '0;
						if (row_last) begin
							mode_d = MODE_DONE;
						end else begin
							row_d  = row_d + POS_W'(1);
							mode_d = MODE_SEEK;
						end
					end else begin
						col_d = col_d + len;
					end
				end else begin
					cnt_d  = b[CNT_W-1:0];
					mode_d = MODE_OPAQUE;
				end
			end
			MODE_OPAQUE: begin
				full = ((col_d + DIM_W'(1)) >= w);
				span_emit            = 1'b1;
				span.span_length     = DIM_W'(1);
				span.palette_index   = b;
				span.opaque          = 1'b1;
				span.row_complete    = full;
				span.sprite_complete = full && row_last;
				cnt_d = cnt_d - CNT_W'(1);
				if (full) begin
					col_d = '0;
					if (row_last) begin
						mode_d = MODE_DONE;
					end else begin
						row_d  = row_d + POS_W'(1);
						mode_d = (cnt_d != '0) ? MODE_SKIPDATA : MODE_SEEK;
					end
				end else begin
					col_d = col_d + DIM_W'(1);
					if (cnt_d == '0)
						mode_d = MODE_CMD;
				end
			end
			MODE_SKIPDATA: begin
				if (cnt_d != '0)
					cnt_d = cnt_d - CNT_W'(1);
				if (cnt_d == '0)
					mode_d = MODE_SEEK;
			end
			MODE_SEEK: begin
				if (b == '0) begin
					mode_d = MODE_CMD;
				end else if (!b[BYTE_W-1]) begin
					cnt_d  = b[CNT_W-1:0];
					mode_d = MODE_SKIPDATA;
				end
			end
			default: begin
				// done: bytes are dropped until the next sprite start
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			mode_q <= MODE_CMD;
			cnt_q  <= '0;
		end else if (fire) begin
			row_q  <= row_d;
			col_q  <= col_d;
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sprite_rle_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_rle_decoder_top
// Row run-length sprite decoder: one encoded byte in, at most one span out.
// ----------------------------------------------------------------------------
// Usage:
//  - Byte channel (byte_valid / byte_stall): one encoded byte per transfer.
//    sprite_start=1 on the first byte of a sprite restarts at row 0, col 0.
//  - Span channel (span_valid / span_stall): one pixel span per transfer;
//    transparent runs come as one span, each palette byte as a 1-pixel span.
//    Opaque-run commands and skipped bytes produce no span.
//  - Config channel (cfg_valid / cfg_ready): index 0 sprite_width,
//    index 1 sprite_height. cfg_ready is always high. Write only while idle.
//  - Path: a transferred byte is captured in the input register, then decoded
//    into the span register once that register can load.
//  - Throughput: one byte per cycle while span_stall does not hold the span
//    register; the decode step between the two registers is combinational.
//  - Span stall: the span register holds; the input register backs up and
//    byte_stall rises only when that register is full and cannot drain.
//  - Reset: both stages empty, decoder at row 0, col 0 expecting a command,
//    width and height back to 1.
// ----------------------------------------------------------------------------
module sprite_rle_decoder_top import srd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// encoded byte stream
	input  wire logic                 byte_valid,
	output      logic                 byte_stall,
	input  wire logic [BYTE_W-1:0]    encoded_byte,
	input  wire logic                 sprite_start,
	// span results
	output      logic                 span_valid,
	input  wire logic                 span_stall,
	output      logic [POS_W-1:0]     span_row,
	output      logic [POS_W-1:0]     span_column,
	output      logic [DIM_W-1:0]     span_length,
	output      logic [BYTE_W-1:0]    palette_index,
	output      logic                 opaque,
	output      logic                 row_complete,
	output      logic                 sprite_complete,
	// configuration writes
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic  valid_s1;
	item_t item_s1;

	logic  out_valid_q;
	span_t out_q;

	logic  out_load;
	logic  fire;
	logic  byte_xfer;
	span_t span;
	logic  span_emit;

	// config registers, raw values; clamping happens in the decode step
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPRITE_WIDTH:  width_q  <= cfg_data;
				REG_SPRITE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// span register is free when empty or being taken this cycle
	assign out_load   = !out_valid_q || !span_stall;
	assign fire       = valid_s1 && out_load;
	assign byte_stall = valid_s1 && !out_load;
	assign byte_xfer  = byte_valid && !byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_xfer)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (byte_xfer) begin
			item_s1.encoded_byte <= encoded_byte;
			item_s1.sprite_start <= sprite_start;
		end
	end

	srd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.sprite_width  (width_q),
		.sprite_height (height_q),
		.span          (span),
		.span_emit     (span_emit)
	);

	// span register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= fire && span_emit;
	end

	always_ff @(posedge clk) begin
		if (fire && span_emit)
			out_q <= span;
	end

	assign span_valid      = out_valid_q;
	assign span_row        = out_q.span_row;
	assign span_column     = out_q.span_column;
	assign span_length     = out_q.span_length;
	assign palette_index   = out_q.palette_index;
	assign opaque          = out_q.opaque;
	assign row_complete    = out_q.row_complete;
	assign sprite_complete = out_q.sprite_complete;

endmodule
`default_nettype wire
